@@ design/hsrd_pkg.sv @@
// Package with the types, constants and helper functions of the humidity sensor reply decoder.
package hsrd_pkg;

  // One reply byte as it arrives from the bus receiver.
  typedef struct packed {
    logic [7:0] reply_byte;
    logic       frame_start;
  } reply_t;

  // One decoded measurement.
  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic [1:0]         status;
  } result_t;

  // Status codes of a result.
  localparam logic [1:0] STATUS_GOOD = 2'd0;
  localparam logic [1:0] STATUS_CRC  = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  // Byte positions within a reply.
  localparam logic [2:0] POS_TEMP_HI  = 3'd0;
  localparam logic [2:0] POS_TEMP_LO  = 3'd1;
  localparam logic [2:0] POS_TEMP_CRC = 3'd2;
  localparam logic [2:0] POS_HUM_HI   = 3'd3;
  localparam logic [2:0] POS_HUM_LO   = 3'd4;
  localparam logic [2:0] POS_HUM_CRC  = 3'd5;

  // CRC-8 settings.
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Conversion scale factors and offsets, in hundredths.
  localparam logic [14:0] TEMP_SPAN      = 15'd17500;
  localparam logic [15:0] TEMP_OFFSET    = 16'd4500;
  localparam logic [14:0] HUM_SPAN_OLD   = 15'd10000;
  localparam logic [14:0] HUM_SPAN_NEW   = 15'd12500;
  localparam logic [15:0] HUM_OFFSET_NEW = 16'd600;
  localparam logic [13:0] HUM_MAX        = 14'd10000;

  // Sensor family codes.
  localparam logic FAMILY_OLD = 1'b0;
  localparam logic FAMILY_NEW = 1'b1;

  // Advance the CRC by one byte, most significant bit first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // Floor of x / 65535 for x below 17501 * 65536. The high half is the quotient
  // estimate; the remainder it leaves is below twice the divisor, so one
  // compare fixes it.
  function automatic logic [14:0] div_65535(input logic [30:0] x);
    logic [14:0] q;
    logic [16:0] r;
    q = x[30:16];
    r = 17'(x[15:0]) + 17'(q);
    if (r >= 17'd65535) begin
      q = q + 15'd1;
    end
    return q;
  endfunction

endpackage

@@ design/humidity_sensor_reply_decoder.sv @@
// Top level of the humidity sensor reply decoder: CRC check, word assembly and conversion.

// The decoder takes the six bytes of a sensor reply one request per cycle:
// temperature word (high byte first), its CRC-8 (polynomial 0x31, init 0xFF),
// humidity word, its CRC-8. A byte with frame_start set restarts the reply;
// otherwise the position count wraps after the sixth byte. The sixth byte
// loads the result register on the same edge that accepts it, so a result
// appears in the cycle after its last byte is accepted. The conversion
// (a constant multiply and a divide by 65535 done as shift plus one
// correction) sits between the stored words and that result register. The
// input stalls only while a finished result waits to be taken. Status is 1 on
// a CRC mismatch (values then read 0) and 2 when both values are zero.
// sensor_family selects the humidity formula: 0 older, 1 newer with clamp to
// 0..100.00 percent; write it only while no reply is in progress.
module humidity_sensor_reply_decoder (
  input  logic             clk,
  input  logic             rst,
  input  logic             reply_valid,
  output logic             reply_ready,
  input  hsrd_pkg::reply_t reply,
  output logic             result_valid,
  input  logic             result_ready,
  output hsrd_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);
  import hsrd_pkg::*;

  logic        sensor_family;
  logic [2:0]  byte_position;
  logic [7:0]  running_crc;
  logic [7:0]  high_byte_store;
  logic [15:0] temperature_word;
  logic [15:0] humidity_word;
  logic        crc_error_seen;

  logic [2:0]  byte_position_next;
  logic [7:0]  running_crc_next;
  logic [7:0]  high_byte_store_next;
  logic [15:0] temperature_word_next;
  logic [15:0] humidity_word_next;
  logic        crc_error_seen_next;

  logic        accept;
  logic [2:0]  pos;
  logic        last_byte;
  logic        crc_fail;
  result_t     result_next;

  logic [30:0]        temp_prod;
  logic [30:0]        hum_prod;
  logic [14:0]        temp_q;
  logic [14:0]        hum_q;
  logic signed [15:0] temp_val;
  logic signed [15:0] hum_new;
  logic [13:0]        hum_val;

  // Handshakes: the result register gates the input, configuration always taken.
  assign reply_ready = !result_valid || result_ready;
  assign cfg_ready   = 1'b1;
  assign accept      = reply_valid && reply_ready;

  // Position of this byte in the reply.
  always_comb begin
    pos = reply.frame_start ? POS_TEMP_HI : byte_position;
    if (pos > POS_HUM_CRC) begin
      pos = POS_TEMP_HI;
    end
  end

  assign last_byte = (pos == POS_HUM_CRC);

  // Reply state update for one accepted byte.
  always_comb begin
    byte_position_next    = last_byte ? POS_TEMP_HI : pos + 3'd1;
    running_crc_next      = running_crc;
    high_byte_store_next  = high_byte_store;
    temperature_word_next = temperature_word;
    humidity_word_next    = humidity_word;
    crc_error_seen_next   = crc_error_seen;
    case (pos)
      POS_TEMP_HI: begin
        crc_error_seen_next  = 1'b0;
        running_crc_next     = crc8_byte(CRC_INIT, reply.reply_byte);
        high_byte_store_next = reply.reply_byte;
      end
      POS_TEMP_LO: begin
        running_crc_next      = crc8_byte(running_crc, reply.reply_byte);
        temperature_word_next = {high_byte_store, reply.reply_byte};
      end
      POS_TEMP_CRC: begin
        if (running_crc != reply.reply_byte) begin
          crc_error_seen_next = 1'b1;
        end
        running_crc_next = CRC_INIT;
      end
      POS_HUM_HI: begin
        running_crc_next     = crc8_byte(CRC_INIT, reply.reply_byte);
        high_byte_store_next = reply.reply_byte;
      end
      POS_HUM_LO: begin
        running_crc_next   = crc8_byte(running_crc, reply.reply_byte);
        humidity_word_next = {high_byte_store, reply.reply_byte};
      end
      POS_HUM_CRC: begin
        running_crc_next = CRC_INIT;
      end
      default: begin
        running_crc_next = running_crc;
      end
    endcase
  end

  // Conversion of the stored words into hundredths.
  always_comb begin
    temp_prod = 31'(temperature_word) * 31'(TEMP_SPAN);
    hum_prod  = 31'(humidity_word) *
                31'((sensor_family == FAMILY_NEW) ? HUM_SPAN_NEW : HUM_SPAN_OLD);
    temp_q    = div_65535(temp_prod);
    hum_q     = div_65535(hum_prod);
    temp_val  = $signed({1'b0, temp_q}) - $signed(TEMP_OFFSET);
    hum_new   = $signed({1'b0, hum_q}) - $signed(HUM_OFFSET_NEW);
    if (sensor_family == FAMILY_OLD) begin
      hum_val = hum_q[13:0];
    end else if (hum_new < 16'sd0) begin
      hum_val = 14'd0;
    end else if (hum_new > $signed({2'b00, HUM_MAX})) begin
      hum_val = HUM_MAX;
    end else begin
      hum_val = hum_new[13:0];
    end
  end

  // Result assembly with status priority.
  assign crc_fail = crc_error_seen || (running_crc != reply.reply_byte);

  always_comb begin
    if (crc_fail) begin
      result_next.temperature_centi = '0;
      result_next.humidity_centi    = '0;
      result_next.status            = STATUS_CRC;
    end else begin
      result_next.temperature_centi = temp_val[14:0];
      result_next.humidity_centi    = hum_val;
      if (temp_val == 16'sd0 && hum_val == 14'd0) begin
        result_next.status = STATUS_ZERO;
      end else begin
        result_next.status = STATUS_GOOD;
      end
    end
  end

  // Control and reply state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_family    <= FAMILY_OLD;
      byte_position    <= POS_TEMP_HI;
      running_crc      <= CRC_INIT;
      high_byte_store  <= '0;
      temperature_word <= '0;
      humidity_word    <= '0;
      crc_error_seen   <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sensor_family <= cfg_data;
      end
      if (accept) begin
        byte_position    <= byte_position_next;
        running_crc      <= running_crc_next;
        high_byte_store  <= high_byte_store_next;
        temperature_word <= temperature_word_next;
        humidity_word    <= humidity_word_next;
        crc_error_seen   <= crc_error_seen_next;
      end
      if (accept && last_byte) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      result <= result_next;
    end
  end

  // The position count never leaves the six byte slots.
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_HUM_CRC)
    else $error("byte position out of range");

  // The last byte of a reply always produces a result on the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> result_valid)
    else $error("last byte accepted without a result");

  // Input stalls only behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !reply_ready |-> (result_valid && !result_ready))
    else $error("input stalled without a pending result");

  // A CRC failure carries zero values.
  a_crc_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STATUS_CRC) |->
      (result.temperature_centi == 15'sd0 && result.humidity_centi == 14'd0))
    else $error("CRC failure with nonzero values");

  // Humidity stays within full scale.
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.humidity_centi <= HUM_MAX))
    else $error("humidity above full scale");

endmodule
